>>> src/pcm_pkg.sv
// Package for the path corridor merge block: widths, codes and state type.
`timescale 1ns / 1ps
`default_nettype none
package pcm_pkg;

	localparam int MAX_PATH_DEF    = 256;
	localparam int VISITED_MAX_DEF = 16;

	localparam int MODE_W = 2;
	localparam int REF_W  = 32;
	localparam int IDX_W  = 8;
	localparam int PL_W   = 9;
	localparam int STAT_W = 2;

	localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
	localparam logic [MODE_W-1:0] MODE_VISIT  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_PATH_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_VIS_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_SADDR,
		ST_SCMP,
		ST_PLAN,
		ST_TRIM,
		ST_MSET,
		ST_MRD,
		ST_MWR,
		ST_FILL,
		ST_FINISH
	} state_t;

endpackage
`default_nettype wire

>>> src/pcm_ram.sv
// Generic single write, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pcm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> src/path_corridor_merge_top.sv
// Path corridor merge: corridor RAM, visited buffer and merge sequencer.
//
// Append and visited transactions complete from the idle state and a read passes through a read
// state; busy stays low for appends and non-final visited entries. A final visited entry runs
// the merge: the corridor is searched one entry at a time from the end (all buffered visited
// entries compared at once), the move is planned and trimmed, the tail entries are moved and
// the visited entries copied in. The single read port of the corridor RAM paces the search
// and the move. Each result is shown for exactly one cycle on done and cannot be held off.
`timescale 1ns / 1ps
`default_nettype none
module path_corridor_merge_top
	import pcm_pkg::*;
#(
	parameter int MAX_PATH    = MAX_PATH_DEF,
	parameter int VISITED_MAX = VISITED_MAX_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [MODE_W-1:0] mode,
	input  wire logic              restart,
	input  wire logic [REF_W-1:0]  poly_ref,
	input  wire logic              last,
	input  wire logic [IDX_W-1:0]  read_index,
	output logic                   done,
	output logic [PL_W-1:0]        path_length,
	output logic [REF_W-1:0]       read_ref,
	output logic                   merged,
	output logic                   truncated,
	output logic [STAT_W-1:0]      status
);

	localparam int AW    = $clog2(MAX_PATH);
	localparam int LEN_W = $clog2(MAX_PATH + 1);
	localparam int VW    = $clog2(VISITED_MAX + 1);
	localparam int VIW   = (VISITED_MAX > 1) ? $clog2(VISITED_MAX) : 1;
	localparam int CW    = LEN_W + IDX_W;

	state_t state_q, state_d;

	logic [LEN_W-1:0]  len_q;
	logic [VW-1:0]     vcnt_q, nv_q;
	logic [REF_W-1:0]  vis_q [VISITED_MAX];
	logic [AW-1:0]     i_q, src_q, dst_q;
	logic [VIW-1:0]    hv_q, vidx_q;
	logic [VW-1:0]     req_q, widx_q;
	logic [LEN_W-1:0]  from_q, size_q, cnt_q;
	logic              fwd_q, hit_q, trunc_q, rd_ok_q;
	logic [STAT_W-1:0] pend_stat_q, status_q;
	logic [REF_W-1:0]  read_ref_q;
	logic              done_q, merged_q, truncated_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [REF_W-1:0]  ram_wdata, ram_rdata;

	logic              acc;
	logic [LEN_W-1:0]  base;
	logic              base_room;
	logic [VW-1:0]     nv_new;
	logic              rd_ok;
	logic              match_any;
	logic [VIW-1:0]    match_idx;
	logic [LEN_W:0]    trim_sum;
	logic [AW+VW-1:0]  widx_ext;
	logic [AW+IDX_W-1:0] ridx_ext;
	logic [PL_W+LEN_W-1:0] plen_ext;
	logic [LEN_W-1:0]  len_m1;

	assign acc       = start && !busy;
	assign base      = restart ? '0 : len_q;
	assign base_room = base < LEN_W'(MAX_PATH);
	assign nv_new    = (vcnt_q < VW'(VISITED_MAX)) ? vcnt_q + 1'b1 : vcnt_q;
	assign rd_ok     = (CW'(read_index) < CW'(len_q)) && (CW'(read_index) < CW'(MAX_PATH));
	assign trim_sum  = (LEN_W+1)'(size_q) + (LEN_W+1)'(req_q);
	assign widx_ext  = (AW+VW)'(widx_q);
	assign ridx_ext  = (AW+IDX_W)'(read_index);
	assign plen_ext  = (PL_W+LEN_W)'(len_q);
	assign len_m1    = len_q - 1'b1;

	// lowest visited lane equal to the corridor word just read
	always_comb begin
		match_any = 1'b0;
		match_idx = '0;
		for (int j = VISITED_MAX - 1; j >= 0; j--) begin
			if ((VW'(j) < nv_q) && (vis_q[j] == ram_rdata)) begin
				match_any = 1'b1;
				match_idx = VIW'(j);
			end
		end
	end

	pcm_ram #(
		.WIDTH(REF_W),
		.DEPTH(MAX_PATH)
	) u_corridor (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && mode == MODE_READ) begin
					state_d = ST_READ;
				end else if (acc && mode == MODE_VISIT && last) begin
					state_d = (len_q != '0) ? ST_SADDR : ST_FINISH;
				end
			end
			ST_READ:  state_d = ST_IDLE;
			ST_SADDR: state_d = ST_SCMP;
			ST_SCMP: begin
				if (match_any) begin
					state_d = ST_PLAN;
				end else if (i_q == '0) begin
					state_d = ST_FINISH;
				end
			end
			ST_PLAN: state_d = ST_TRIM;
			ST_TRIM: state_d = ST_MSET;
			ST_MSET: begin
				if (size_q == '0 || LEN_W'(req_q) == from_q) begin
					state_d = ST_FILL;
				end else begin
					state_d = ST_MRD;
				end
			end
			ST_MRD: state_d = ST_MWR;
			ST_MWR: state_d = (cnt_q == LEN_W'(1)) ? ST_FILL : ST_MRD;
			ST_FILL: begin
				if (widx_q == req_q - 1'b1) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = (state_q != ST_IDLE);
		ram_we    = 1'b0;
		ram_waddr = base[AW-1:0];
		ram_wdata = poly_ref;
		ram_raddr = ridx_ext[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				ram_we = acc && (mode == MODE_APPEND) && base_room;
			end
			ST_SADDR: ram_raddr = i_q;
			ST_SCMP:  ram_raddr = i_q - 1'b1;
			ST_MRD:   ram_raddr = src_q;
			ST_MWR: begin
				ram_we    = 1'b1;
				ram_waddr = dst_q;
				ram_wdata = ram_rdata;
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = widx_ext[AW-1:0];
				ram_wdata = vis_q[vidx_q];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			vcnt_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (mode)
							MODE_APPEND: begin
								len_q  <= base_room ? base + 1'b1 : base;
								done_q <= 1'b1;
							end
							MODE_VISIT: begin
								vcnt_q <= last ? '0 : nv_new;
								done_q <= !last;
							end
							MODE_READ: begin
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				ST_READ: done_q <= 1'b1;
				ST_FINISH: begin
					done_q <= 1'b1;
					if (hit_q) begin
						len_q <= LEN_W'(req_q) + size_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					hit_q       <= 1'b0;
					trunc_q     <= 1'b0;
					rd_ok_q     <= rd_ok;
					nv_q        <= nv_new;
					i_q         <= len_m1[AW-1:0];
					pend_stat_q <= STAT_OK;
					read_ref_q  <= '0;
					merged_q    <= 1'b0;
					truncated_q <= 1'b0;
					case (mode)
						MODE_APPEND: status_q <= base_room ? STAT_OK : STAT_PATH_FULL;
						MODE_VISIT: begin
							if (vcnt_q < VW'(VISITED_MAX)) begin
								vis_q[vcnt_q[VIW-1:0]] <= poly_ref;
								status_q    <= STAT_OK;
								pend_stat_q <= STAT_OK;
							end else begin
								status_q    <= STAT_VIS_FULL;
								pend_stat_q <= STAT_VIS_FULL;
							end
						end
						default: status_q <= STAT_OK;
					endcase
				end
			end
			ST_READ: begin
				read_ref_q <= rd_ok_q ? ram_rdata : '0;
				status_q   <= rd_ok_q ? STAT_OK : STAT_BAD_INDEX;
			end
			ST_SCMP: begin
				if (match_any) begin
					hit_q <= 1'b1;
					hv_q  <= match_idx;
				end else if (i_q != '0) begin
					i_q <= i_q - 1'b1;
				end
			end
			ST_PLAN: begin
				req_q  <= nv_q - VW'(hv_q);
				from_q <= LEN_W'(i_q) + 1'b1;
				size_q <= len_q - (LEN_W'(i_q) + 1'b1);
			end
			ST_TRIM: begin
				if (trim_sum > (LEN_W+1)'(MAX_PATH)) begin
					size_q  <= LEN_W'(MAX_PATH) - LEN_W'(req_q);
					trunc_q <= 1'b1;
				end
			end
			ST_MSET: begin
				fwd_q  <= LEN_W'(req_q) < from_q;
				cnt_q  <= size_q;
				widx_q <= '0;
				vidx_q <= VIW'(nv_q - 1'b1);
				if (LEN_W'(req_q) < from_q) begin
					src_q <= from_q[AW-1:0];
					dst_q <= AW'(req_q);
				end else begin
					src_q <= AW'(from_q + size_q - 1'b1);
					dst_q <= AW'(LEN_W'(req_q) + size_q - 1'b1);
				end
			end
			ST_MWR: begin
				cnt_q <= cnt_q - 1'b1;
				src_q <= fwd_q ? src_q + 1'b1 : src_q - 1'b1;
				dst_q <= fwd_q ? dst_q + 1'b1 : dst_q - 1'b1;
			end
			ST_FILL: begin
				widx_q <= widx_q + 1'b1;
				vidx_q <= vidx_q - 1'b1;
			end
			ST_FINISH: begin
				status_q    <= pend_stat_q;
				merged_q    <= hit_q;
				truncated_q <= hit_q && trunc_q;
				read_ref_q  <= '0;
			end
			default: begin
			end
		endcase
	end

	assign done        = done_q;
	assign path_length = plen_ext[PL_W-1:0];
	assign read_ref    = read_ref_q;
	assign merged      = merged_q;
	assign truncated   = truncated_q;
	assign status      = status_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_PATH))
		else $error("corridor length beyond capacity");

	a_vis_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q <= VW'(VISITED_MAX))
		else $error("visited count beyond capacity");

	a_append_done: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && mode == MODE_APPEND) |=> (done && !merged && read_ref == '0))
		else $error("append transaction did not complete in one cycle");

	a_trunc_merged: assert property (@(posedge clk) disable iff (!arst_n)
		(done && truncated) |-> merged)
		else $error("truncation reported without a merge");

	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |=> (done && !busy))
		else $error("merge finished without a result strobe");

endmodule
`default_nettype wire

>>> sim/path_corridor_merge_top_tb.sv
// Testbench for path_corridor_merge_top: queued transactions, corridor predictor, result checks.
`timescale 1ns / 1ps
module path_corridor_merge_top_tb;
	import pcm_pkg::*;

	localparam int CORR_CAP     = MAX_PATH_DEF;
	localparam int VIS_CAP      = VISITED_MAX_DEF;
	localparam int RAND_ITEMS   = 700;
	localparam int CALM_AFTER   = 600;
	localparam int DRAIN_CYCLES = 1000;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int PRINT_LIMIT  = 50;

	localparam logic [MODE_W-1:0] MODE_IDLE = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              restart;
		logic [REF_W-1:0]  poly_ref;
		logic              last;
		logic [IDX_W-1:0]  read_index;
	} corr_cmd_t;

	typedef struct packed {
		logic [PL_W-1:0]   path_length;
		logic [REF_W-1:0]  read_ref;
		logic              merged;
		logic              truncated;
		logic [STAT_W-1:0] status;
	} corr_resp_t;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              start      = 1'b0;
	logic [MODE_W-1:0] mode       = '0;
	logic              restart    = 1'b0;
	logic [REF_W-1:0]  poly_ref   = '0;
	logic              last       = 1'b0;
	logic [IDX_W-1:0]  read_index = '0;
	logic              busy;
	logic              done;
	logic [PL_W-1:0]   path_length;
	logic [REF_W-1:0]  read_ref;
	logic              merged;
	logic              truncated;
	logic [STAT_W-1:0] status;

	path_corridor_merge_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.restart    (restart),
		.poly_ref   (poly_ref),
		.last       (last),
		.read_index (read_index),
		.done       (done),
		.path_length(path_length),
		.read_ref   (read_ref),
		.merged     (merged),
		.truncated  (truncated),
		.status     (status)
	);

	always #5 clk = ~clk;

	// predicted corridor and visited buffer
	logic [REF_W-1:0] corr_mem [CORR_CAP];
	logic [REF_W-1:0] tail_buf [CORR_CAP];
	logic [REF_W-1:0] vis_mem  [VIS_CAP];
	int               corr_len = 0;
	int               vis_cnt  = 0;

	corr_cmd_t  pend_q[$];
	corr_resp_t resp_q[$];
	corr_cmd_t  cur_cmd;
	corr_cmd_t  nxt_cmd;
	corr_resp_t new_resp;
	corr_resp_t want;

	int n_queued   = 0;
	int n_useful   = 0;
	int n_accepted = 0;
	int n_checked  = 0;
	int n_errors   = 0;
	int gap_left   = 0;
	int cycle_cnt  = 0;
	bit idle_en    = 1'b1;
	bit calm       = 1'b0;

	task automatic report_mismatch(input string what, input logic [REF_W-1:0] got,
			input logic [REF_W-1:0] exp_val);
		n_errors++;
		if (n_errors <= PRINT_LIMIT)
			$display("%0t ns: mismatch on %s, got %0h, expected %0h", $time, what, got, exp_val);
	endtask

	// fold the visited list into the corridor start
	task automatic fold_visited(output logic hit, output logic cut);
		int hit_path;
		int hit_vis;
		int req;
		int from;
		int size;
		hit = 1'b0;
		cut = 1'b0;
		hit_path = 0;
		hit_vis = 0;
		for (int i = corr_len; i > 0 && !hit; i--)
			for (int j = 0; j < vis_cnt && !hit; j++)
				if (corr_mem[i-1] == vis_mem[j]) begin
					hit = 1'b1;
					hit_path = i - 1;
					hit_vis = j;
				end
		if (hit) begin
			req = vis_cnt - hit_vis;
			from = hit_path + 1;
			size = corr_len - from;
			if (req + size > CORR_CAP) begin
				size = CORR_CAP - req;
				cut = 1'b1;
			end
			for (int k = 0; k < size; k++)
				tail_buf[k] = corr_mem[from + k];
			for (int k = 0; k < size; k++)
				corr_mem[req + k] = tail_buf[k];
			for (int k = 0; k < req; k++)
				corr_mem[k] = vis_mem[vis_cnt - 1 - k];
			corr_len = req + size;
		end
	endtask

	task automatic predict_corridor(input corr_cmd_t c, output corr_resp_t r);
		logic hit;
		logic cut;
		r = '0;
		case (c.mode)
			MODE_APPEND: begin
				if (c.restart)
					corr_len = 0;
				if (corr_len < CORR_CAP) begin
					corr_mem[corr_len] = c.poly_ref;
					corr_len++;
				end else
					r.status = STAT_PATH_FULL;
			end
			MODE_VISIT: begin
				if (vis_cnt < VIS_CAP) begin
					vis_mem[vis_cnt] = c.poly_ref;
					vis_cnt++;
				end else
					r.status = STAT_VIS_FULL;
				if (c.last) begin
					fold_visited(hit, cut);
					r.merged = hit;
					r.truncated = cut;
					vis_cnt = 0;
				end
			end
			MODE_READ: begin
				if (c.read_index < corr_len)
					r.read_ref = corr_mem[c.read_index];
				else
					r.status = STAT_BAD_INDEX;
			end
			default: ;
		endcase
		r.path_length = PL_W'(corr_len);
	endtask

	task automatic push_cmd(input logic [MODE_W-1:0] m, input logic rs,
			input logic [REF_W-1:0] pr, input logic lst, input logic [IDX_W-1:0] ix);
		corr_cmd_t c;
		c.mode = m;
		c.restart = rs;
		c.poly_ref = pr;
		c.last = lst;
		c.read_index = ix;
		pend_q.push_back(c);
		n_queued++;
		if (m != MODE_IDLE)
			n_useful++;
	endtask

	// every queued transaction accepted, so the predicted state is current
	task automatic settle();
		wait (n_accepted == n_queued);
	endtask

	function automatic logic [REF_W-1:0] pick_ref();
		if (corr_len > 0 && $urandom_range(0, 1) == 1)
			return corr_mem[$urandom_range(0, corr_len - 1)];
		return $urandom();
	endfunction

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			mode <= '0;
			restart <= 1'b0;
			poly_ref <= '0;
			last <= 1'b0;
			read_index <= '0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				predict_corridor(cur_cmd, new_resp);
				resp_q.push_back(new_resp);
				n_accepted <= n_accepted + 1;
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (pend_q.size() > 0 && idle_en && !calm
						&& $urandom_range(0, 9) == 0) begin
					gap_left <= $urandom_range(0, 18);
					start <= 1'b0;
				end else if (pend_q.size() > 0) begin
					nxt_cmd = pend_q.pop_front();
					cur_cmd <= nxt_cmd;
					mode <= nxt_cmd.mode;
					restart <= nxt_cmd.restart;
					poly_ref <= nxt_cmd.poly_ref;
					last <= nxt_cmd.last;
					read_index <= nxt_cmd.read_index;
					start <= 1'b1;
				end else
					start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (resp_q.size() == 0)
				report_mismatch("result with no transaction pending", '0, '0);
			else begin
				want = resp_q.pop_front();
				n_checked <= n_checked + 1;
				if (path_length !== want.path_length)
					report_mismatch("path_length", REF_W'(path_length), REF_W'(want.path_length));
				if (read_ref !== want.read_ref)
					report_mismatch("read_ref", read_ref, want.read_ref);
				if (merged !== want.merged)
					report_mismatch("merged", REF_W'(merged), REF_W'(want.merged));
				if (truncated !== want.truncated)
					report_mismatch("truncated", REF_W'(truncated), REF_W'(want.truncated));
				if (status !== want.status)
					report_mismatch("status", REF_W'(status), REF_W'(want.status));
			end
		end
	end

	initial begin
		int pick;
		int n;
		int idx;
		bit rs;
		bit broken;
		logic [REF_W-1:0] anchor;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty corridor, unused mode, merge with no match
		push_cmd(MODE_READ, 1'b0, '1, 1'b0, 8'd0);
		push_cmd(MODE_IDLE, 1'b1, '1, 1'b1, '1);
		push_cmd(MODE_VISIT, 1'b0, 32'h1234_5678, 1'b1, 8'd0);
		push_cmd(MODE_APPEND, 1'b1, 32'h0000_0000, 1'b0, 8'd0);
		push_cmd(MODE_APPEND, 1'b0, 32'hFFFF_FFFF, 1'b0, 8'd0);
		push_cmd(MODE_APPEND, 1'b0, 32'hA5A5_A5A5, 1'b0, 8'd0);
		push_cmd(MODE_APPEND, 1'b0, 32'h5A5A_5A5A, 1'b0, 8'd0);
		push_cmd(MODE_READ, 1'b0, '1, 1'b0, 8'd0);
		push_cmd(MODE_READ, 1'b0, '1, 1'b0, 8'd3);
		push_cmd(MODE_READ, 1'b0, '0, 1'b0, 8'd4);
		push_cmd(MODE_READ, 1'b0, '0, 1'b0, 8'd255);
		push_cmd(MODE_VISIT, 1'b0, 32'h1234_5678, 1'b0, 8'd0);
		push_cmd(MODE_VISIT, 1'b0, 32'hFFFF_FFFF, 1'b1, 8'd0);
		push_cmd(MODE_READ, 1'b0, '0, 1'b0, 8'd0);
		// ignored fields in the visited, append and read modes
		push_cmd(MODE_VISIT, 1'b1, 32'h0000_0000, 1'b0, 8'd255);
		push_cmd(MODE_VISIT, 1'b1, 32'hA5A5_A5A5, 1'b1, 8'd255);
		push_cmd(MODE_APPEND, 1'b0, 32'hC3C3_C3C3, 1'b1, 8'd255);
		push_cmd(MODE_READ, 1'b1, '1, 1'b1, 8'd2);
		push_cmd(MODE_READ, 1'b0, '1, 1'b0, 8'd1);
		settle();

		// full corridor, then a merge with a full visited list that truncates the tail
		push_cmd(MODE_APPEND, 1'b1, $urandom(), 1'b0, 8'($urandom()));
		for (int k = 0; k < CORR_CAP + 3; k++)
			push_cmd(MODE_APPEND, 1'b0, $urandom(), 1'($urandom_range(0, 1)), 8'($urandom()));
		settle();
		anchor = corr_mem[0];
		push_cmd(MODE_VISIT, 1'b0, anchor, 1'b0, 8'($urandom()));
		for (int k = 1; k < VIS_CAP; k++)
			push_cmd(MODE_VISIT, 1'($urandom_range(0, 1)), $urandom(), 1'b0, 8'($urandom()));
		push_cmd(MODE_VISIT, 1'b0, $urandom(), 1'b1, 8'($urandom()));
		push_cmd(MODE_READ, 1'b0, $urandom(), 1'b0, 8'd255);
		settle();

		while (n_useful < RAND_ITEMS) begin
			calm = (n_useful > CALM_AFTER);
			idle_en = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 19);
			if (pick < 6) begin
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(240, 270) : $urandom_range(1, 12);
				rs = ($urandom_range(0, 2) == 0);
				for (int k = 0; k < n; k++)
					push_cmd(MODE_APPEND, (k == 0) ? rs : ($urandom_range(0, 31) == 0),
						$urandom(), 1'($urandom_range(0, 1)), 8'($urandom()));
			end else if (pick < 13) begin
				n = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 19) : $urandom_range(1, 6);
				broken = ($urandom_range(0, 7) == 0);
				for (int k = 0; k < n; k++)
					push_cmd(MODE_VISIT, 1'($urandom_range(0, 1)), pick_ref(),
						(k == n - 1) && !broken, 8'($urandom()));
			end else if (pick < 17) begin
				n = $urandom_range(1, 6);
				for (int k = 0; k < n; k++) begin
					if (corr_len > 0 && $urandom_range(0, 3) != 0)
						idx = $urandom_range(0, corr_len - 1);
					else
						idx = $urandom_range(0, 255);
					push_cmd(MODE_READ, 1'($urandom_range(0, 1)), $urandom(),
						1'($urandom_range(0, 1)), 8'(idx));
				end
			end else begin
				n = $urandom_range(1, 4);
				for (int k = 0; k < n; k++)
					push_cmd(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom(),
						1'($urandom_range(0, 1)), 8'($urandom()));
			end
			settle();
		end

		wait (n_checked == n_queued);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
